// ===== hdl/bsb_pkg.sv =====
// ----------------------------------------------------------------------------
// bsb_pkg: shared constants of the bounded step backtrack unit
// Holds the fixed-point constants and the sequencer state codes.
// ----------------------------------------------------------------------------
package bsb_pkg;

    // Q1.16 full step (1.0)
    localparam int unsigned FRAC_BITS = 16;
    localparam logic [16:0] FULL_STEP = 17'h10000;
    localparam int unsigned FRAC_WIDTH = 17;

    // sequencer states
    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

endpackage

// ===== hdl/bsb_if.sv =====
// ----------------------------------------------------------------------------
// bsb_in_if / bsb_out_if: valid/ready channels of the backtrack unit
// Input carries one element word, output one corrected element word.
// ----------------------------------------------------------------------------
interface bsb_in_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] old_value;
    logic signed [VALUE_WIDTH-1:0] new_value;
    logic signed [VALUE_WIDTH-1:0] lower_bound;
    logic signed [VALUE_WIDTH-1:0] upper_bound;
    logic                          is_bounded;
    logic                          last_in;
    modport source (output valid, old_value, new_value, lower_bound, upper_bound,
                    is_bounded, last_in, input ready);
    modport sink   (input valid, old_value, new_value, lower_bound, upper_bound,
                    is_bounded, last_in, output ready);
endinterface

interface bsb_out_if #(parameter int VALUE_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] corrected_value;
    logic [16:0]                   step_fraction;
    logic                          last_out;
    modport source (output valid, corrected_value, step_fraction, last_out,
                    input ready);
    modport sink   (input valid, corrected_value, step_fraction, last_out,
                    output ready);
endinterface

// ===== hdl/bounded_step_backtrack_unit.sv =====
// Intake: an element that needs a step fraction holds the input while the divider
// starts, forms its 16 quotient bits and updates the minimum; others do not hold it.
// Emission: each output word passes RAM read, operand latch, multiply (when the
// product is nonzero) and output register, and waits on any receiver stall.
// No new element is taken while a division or an emission is under way.
// Reset: synchronous active low; resets count and minimum fraction, clears clamp mode.
// ----------------------------------------------------------------------------
// bounded_step_backtrack_unit: fraction-to-boundary backtracking
// Stores each element up to MAX_ELEMENTS, tracks the minimum step fraction and
// emits the interpolated vector, clamped where bounded, on the last element.
// ----------------------------------------------------------------------------
module bounded_step_backtrack_unit #(
    parameter int MAX_ELEMENTS = 64,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    bsb_in_if.sink      i_in,
    bsb_out_if.source   o_out
);
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int SW = 4 * VW + 1;
    localparam int PW = VW + 1 + bsb_pkg::FRAC_WIDTH + 1;

    logic [2:0]    r_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_idx;
    logic [16:0]   r_min;
    logic [16:0]   r_beta;
    logic          r_clamp;
    logic          r_last;

    // element in flight
    logic signed [VW:0] r_diff;
    logic signed [PW-1:0] r_prod;
    logic signed [VW-1:0] r_old;
    logic signed [VW-1:0] r_lo;
    logic signed [VW-1:0] r_hi;
    logic                 r_bnd;
    logic                 r_ovalid;
    logic signed [VW-1:0] r_oval;
    logic                 r_olast;

    // store element words in one RAM
    logic          w_we;
    logic [SW-1:0] w_wdata;
    logic [SW-1:0] w_rdata;
    logic          w_full;
    logic          w_acc;

    assign w_full  = (r_count == CW'(MAX_ELEMENTS));
    assign i_in.ready = (r_state == bsb_pkg::ST_LOAD) && !r_ovalid;
    assign w_acc   = i_in.valid && i_in.ready;
    assign w_we    = w_acc && !w_full;
    assign w_wdata = {i_in.is_bounded, i_in.upper_bound, i_in.lower_bound,
                      i_in.new_value, i_in.old_value};

    bsb_ram #(.WIDTH(SW), .DEPTH(MAX_ELEMENTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(r_idx),
        .o_rdata(w_rdata)
    );

    // fraction operands of the arriving element
    logic signed [VW:0] w_o, w_n, w_lo, w_hi, w_num, w_den;
    logic               w_up, w_dn, w_need;
    logic [VW:0]        w_anum, w_aden;
    assign w_o  = {i_in.old_value[VW-1], i_in.old_value};
    assign w_n  = {i_in.new_value[VW-1], i_in.new_value};
    assign w_lo = {i_in.lower_bound[VW-1], i_in.lower_bound};
    assign w_hi = {i_in.upper_bound[VW-1], i_in.upper_bound};
    assign w_up = (w_n > w_hi) && (w_o < w_hi);
    assign w_dn = (w_n < w_lo) && (w_o > w_lo);
    assign w_need = i_in.is_bounded && !r_clamp && (w_n != w_o) && (w_up || w_dn);
    assign w_num  = w_up ? (w_hi - w_o) : (w_o - w_lo);
    assign w_den  = w_up ? (w_n - w_o) : (w_o - w_n);
    assign w_anum = w_num;
    assign w_aden = w_den;

    logic        w_div_start;
    logic        w_div_done;
    logic [15:0] w_quot;
    assign w_div_start = w_we && w_need;

    bsb_divider #(.VALUE_WIDTH(VW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_anum),
        .i_den  (w_aden),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // stored entry fields
    logic signed [VW-1:0] w_ro, w_rn, w_rlo, w_rhi;
    logic                 w_rb;
    assign w_ro  = w_rdata[VW-1:0];
    assign w_rn  = w_rdata[2*VW-1:VW];
    assign w_rlo = w_rdata[3*VW-1:2*VW];
    assign w_rhi = w_rdata[4*VW-1:3*VW];
    assign w_rb  = w_rdata[SW-1];

    // floor shift of the product, then clamp
    logic signed [PW-1:0] w_sh;
    logic signed [VW:0]   w_v;
    logic signed [VW-1:0] w_cl;
    assign w_sh = r_prod >>> bsb_pkg::FRAC_BITS;
    assign w_v  = {r_old[VW-1], r_old} + w_sh[VW:0];
    always_comb begin
        w_cl = w_v[VW-1:0];
        if (r_bnd) begin
            if (w_cl < r_lo) begin
                w_cl = r_lo;
            end
            if (w_cl > r_hi) begin
                w_cl = r_hi;
            end
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.corrected_value = r_oval;
    assign o_out.step_fraction   = r_beta;
    assign o_out.last_out        = r_olast;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bsb_pkg::ST_LOAD;
            r_count  <= '0;
            r_idx    <= '0;
            r_min    <= bsb_pkg::FULL_STEP;
            r_beta   <= bsb_pkg::FULL_STEP;
            r_clamp  <= 1'b0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_clamp <= i_cfg_wdata;
            end
            if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                bsb_pkg::ST_LOAD: begin
                    if (w_acc) begin
                        if (w_we) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_last <= i_in.last_in;
                        if (w_div_start) begin
                            r_state <= bsb_pkg::ST_DIV;
                        end else if (i_in.last_in) begin
                            r_idx   <= '0;
                            r_beta  <= r_clamp ? bsb_pkg::FULL_STEP : r_min;
                            r_state <= bsb_pkg::ST_RD;
                        end
                    end
                end
                bsb_pkg::ST_DIV: begin
                    if (w_div_done) begin
                        if ({1'b0, w_quot} < r_min) begin
                            r_min <= {1'b0, w_quot};
                        end
                        if (r_last) begin
                            r_idx   <= '0;
                            r_beta  <= r_clamp ? bsb_pkg::FULL_STEP :
                                       (({1'b0, w_quot} < r_min) ? {1'b0, w_quot} : r_min);
                            r_state <= bsb_pkg::ST_RD;
                        end else begin
                            r_state <= bsb_pkg::ST_LOAD;
                        end
                    end
                end
                bsb_pkg::ST_RD: begin
                    // RAM read data valid next cycle
                    r_state <= bsb_pkg::ST_MUL;
                end
                bsb_pkg::ST_MUL: begin
                    r_diff  <= {w_rn[VW-1], w_rn} - {w_ro[VW-1], w_ro};
                    r_old   <= w_ro;
                    r_lo    <= w_rlo;
                    r_hi    <= w_rhi;
                    r_bnd   <= w_rb;
                    r_state <= bsb_pkg::ST_EMIT;
                    r_prod  <= '0;
                end
                bsb_pkg::ST_EMIT: begin
                    if (!r_ovalid && r_prod == '0 && r_diff != '0
                        && r_prod != PW'($signed(r_diff) * $signed({1'b0, r_beta}))) begin
                        r_prod <= PW'($signed(r_diff) * $signed({1'b0, r_beta}));
                    end else if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= w_cl;
                        r_olast  <= (CW'(r_idx) == r_count - CW'(1));
                        if (CW'(r_idx) == r_count - CW'(1)) begin
                            r_state <= bsb_pkg::ST_LOAD;
                            r_count <= '0;
                            r_min   <= bsb_pkg::FULL_STEP;
                            r_last  <= 1'b0;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= bsb_pkg::ST_RD;
                        end
                    end
                end
                default: begin
                    r_state <= bsb_pkg::ST_LOAD;
                end
            endcase
        end
    end
endmodule

// ===== hdl/bsb_ram.sv =====
// ----------------------------------------------------------------------------
// bsb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/bsb_divider.sv =====
// ----------------------------------------------------------------------------
// bsb_divider: restoring divider for the Q0.16 step fraction
// Forms floor(n * 2^16 / d) for n < d, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsb_divider #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [VALUE_WIDTH:0] i_num,
    input  logic [VALUE_WIDTH:0] i_den,
    output logic                 o_done,
    output logic [15:0]          o_quot
);
    localparam int RW = VALUE_WIDTH + 2;

    logic [RW-1:0]        r_rem;
    logic [VALUE_WIDTH:0] r_den;
    logic [15:0]          r_quot;
    logic [4:0]           r_cnt;
    logic                 r_busy;
    logic [RW-1:0]        w_shift;
    logic [RW-1:0]        w_den_x;

    assign w_shift = {r_rem[RW-2:0], 1'b0};
    assign w_den_x = {1'b0, r_den};
    assign o_quot  = r_quot;

    // shift-subtract, one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                if (w_shift >= w_den_x) begin
                    r_rem  <= w_shift - w_den_x;
                    r_quot <= {r_quot[14:0], 1'b1};
                end else begin
                    r_rem  <= w_shift;
                    r_quot <= {r_quot[14:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== hdl/bsb_checker.sv =====
// ----------------------------------------------------------------------------
// bsb_checker: port-level checks of the backtrack unit
// Watches handshakes and reset behavior at the top level's ports.
// ----------------------------------------------------------------------------
module bsb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [16:0] i_step_fraction,
    input logic        i_last_out
);
    // no word pending right after reset
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a stalled word keeps its valid, step fraction and last flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_step_fraction)
            && $stable(i_last_out))
        else $error("stalled output word changed");

    // no intake while a word waits
    a_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while output pending");

    // step fraction never above full step
    a_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_step_fraction <= 17'h10000)
        else $error("step fraction above one");
endmodule

bind bounded_step_backtrack_unit bsb_checker u_bsb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_step_fraction(o_out.step_fraction),
    .i_last_out     (o_out.last_out)
);

// ===== test/bounded_step_backtrack_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_step_backtrack_unit_test: self-checking bench of the backtrack unit
// Feeds element vectors, predicts the minimum step fraction and the corrected
// words, and compares every output word with the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_step_backtrack_unit_test;

    localparam int MAX_EL    = 64;
    localparam int CYCLE_CAP = 1500000;

    typedef struct packed {
        logic signed [31:0] value;
        logic [16:0]        fraction;
        logic               last;
    } t_word;

    typedef struct {
        logic signed [31:0] old_v;
        logic signed [31:0] new_v;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               bnd;
    } t_elem;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;

    bsb_in_if  #(.VALUE_WIDTH(32)) in_ch ();
    bsb_out_if #(.VALUE_WIDTH(32)) out_ch ();

    bounded_step_backtrack_unit #(.MAX_ELEMENTS(MAX_EL), .VALUE_WIDTH(32)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    t_elem       stored[MAX_EL];
    int          stored_count = 0;
    logic [16:0] min_beta = bsb_pkg::FULL_STEP;
    logic        clamp_mode = 1'b0;
    t_word       expected_words[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          hold_off = 0;

    function automatic logic [16:0] boundary_fraction(longint num, longint den);
        longint n, d, q;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = (n <<< 16) / d;
        return q > 65536 ? bsb_pkg::FULL_STEP : q[16:0];
    endfunction

    function automatic longint step_toward(longint o, longint n, logic [16:0] beta);
        longint prod;
        prod = (n - o) * longint'(beta);
        if (prod >= 0) return o + (prod >>> 16);
        return o - ((-prod + 65535) >>> 16);
    endfunction

    // advance the predictor by one accepted word
    task automatic predict_element(t_elem e, logic last);
        logic [16:0] f, beta;
        longint v;
        if (stored_count < MAX_EL) begin
            stored[stored_count] = e;
            stored_count++;
            if (e.bnd && !clamp_mode && e.new_v != e.old_v) begin
                f = bsb_pkg::FULL_STEP;
                if (e.new_v > e.hi && e.old_v < e.hi)
                    f = boundary_fraction(longint'(e.hi) - e.old_v,
                                          longint'(e.new_v) - e.old_v);
                else if (e.new_v < e.lo && e.old_v > e.lo)
                    f = boundary_fraction(longint'(e.lo) - e.old_v,
                                          longint'(e.new_v) - e.old_v);
                if (f < min_beta) min_beta = f;
            end
        end
        if (last) begin
            beta = clamp_mode ? bsb_pkg::FULL_STEP : min_beta;
            for (int k = 0; k < stored_count; k++) begin
                v = step_toward(stored[k].old_v, stored[k].new_v, beta);
                if (stored[k].bnd) begin
                    if (v < stored[k].lo) v = stored[k].lo;
                    if (v > stored[k].hi) v = stored[k].hi;
                end
                expected_words.push_back('{v[31:0], beta, k + 1 == stored_count});
            end
            stored_count = 0;
            min_beta = bsb_pkg::FULL_STEP;
        end
    endtask

    // count cycles; give up at the cap
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("bounded_step_backtrack_unit_test: errors");
            $finish;
        end
    end

    // receiver: random stalls plus an optional long hold-off
    initial out_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) < 8) ? 1'b0
                          : ($urandom_range(0, 99) < 30 ? 1'b1 : ($urandom_range(0, 3) != 0));
        end
    end

    // check each output word against the oldest prediction
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word value=%0d", out_ch.corrected_value);
                error_count++;
            end else begin
                w = expected_words.pop_front();
                if (out_ch.corrected_value !== w.value) begin
                    $error("corrected_value exp %0d got %0d", w.value,
                           out_ch.corrected_value);
                    error_count++;
                end
                if (out_ch.step_fraction !== w.fraction) begin
                    $error("step_fraction exp %0d got %0d", w.fraction,
                           out_ch.step_fraction);
                    error_count++;
                end
                if (out_ch.last_out !== w.last) begin
                    $error("last_out exp %0d got %0d", w.last, out_ch.last_out);
                    error_count++;
                end
            end
        end
    end

    // send one word, with a random gap first
    task automatic send_element(t_elem e, logic last);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.old_value   <= e.old_v;
        in_ch.new_value   <= e.new_v;
        in_ch.lower_bound <= e.lo;
        in_ch.upper_bound <= e.hi;
        in_ch.is_bounded  <= e.bnd;
        in_ch.last_in     <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_element(e, last);
    endtask

    task automatic drain_outputs();
        @(posedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_clamp_mode(logic mode);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        clamp_mode = mode;
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 65536 * 8) - 65536 * 4;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed element: old inside the box, new often outside
    function automatic t_elem rand_element();
        t_elem e;
        logic signed [31:0] a, b;
        if ($urandom_range(0, 9) == 0) begin
            e.old_v = rand_value(); e.new_v = rand_value();
            e.lo = rand_value(); e.hi = rand_value();
            e.bnd = 1'($urandom_range(0, 1));
            return e;
        end
        a = $urandom_range(0, 1 << 24) - (1 << 23);
        b = $urandom_range(0, 1 << 24) - (1 << 23);
        e.lo = a < b ? a : b;
        e.hi = a < b ? b : a;
        e.old_v = 32'(e.lo + ((longint'(e.hi) - e.lo) * $urandom_range(0, 100)) / 100);
        e.new_v = $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 1 << 26) - (1 << 25));
        if ($urandom_range(0, 15) == 0) e.new_v = e.old_v;
        e.bnd = $urandom_range(0, 4) != 0;
        return e;
    endfunction

    task automatic send_vector(int len);
        for (int k = 0; k < len; k++) send_element(rand_element(), k == len - 1);
    endtask

    task automatic test_directed();
        t_elem e;
        // leaves through the upper bound
        e = '{32'sd0, 32'sd4 <<< 16, -(32'sd1 <<< 16), 32'sd1 <<< 16, 1'b1};
        send_element(e, 1'b0);
        // leaves through the lower bound, free element, unchanged element
        e = '{32'sd0, -(32'sd8 <<< 16), -(32'sd1 <<< 16), 32'sd1 <<< 16, 1'b1};
        send_element(e, 1'b0);
        e = '{32'sd5, -32'sd77, 32'sd0, 32'sd0, 1'b0};
        send_element(e, 1'b0);
        e = '{32'sd9, 32'sd9, 32'sd0, 32'sd3, 1'b1};
        send_element(e, 1'b0);
        // inverted box; extremes; step leaving both sides
        e = '{32'sd10, 32'sd20, 32'sd30, 32'sd0, 1'b1};
        send_element(e, 1'b0);
        e = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1};
        send_element(e, 1'b0);
        e = '{32'sh7fffffff, 32'sh80000000, 32'sh7ffffffe, 32'sh7fffffff, 1'b1};
        send_element(e, 1'b0);
        e = '{32'sd0, 32'sd1000, 32'sd10, -32'sd10, 1'b1};
        send_element(e, 1'b1);
        // single-element vectors
        e = '{-32'sd3, 32'sd3, -32'sd1, 32'sd1, 1'b1};
        send_element(e, 1'b1);
        e = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b0};
        send_element(e, 1'b1);
        drain_outputs();
    endtask

    task automatic test_full_buffer();
        // two extra elements past capacity are dropped
        send_vector(MAX_EL + 2);
        drain_outputs();
    endtask

    task automatic test_clamp_mode();
        write_clamp_mode(1'b1);
        send_vector(5);
        send_vector(1);
        drain_outputs();
        write_clamp_mode(1'b0);
        send_vector(4);
        drain_outputs();
    endtask

    task automatic test_back_pressure();
        // receiver stays off past the first vector; the second one stalls
        hold_off = 3000;
        send_vector(40);
        send_vector(6);
        drain_outputs();
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 220) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
            send_vector(len);
            sent += len;
            if ($urandom_range(0, 7) == 0) begin
                drain_outputs();
                write_clamp_mode($urandom_range(0, 3) == 0);
            end
        end
        drain_outputs();
        write_clamp_mode(1'b0);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.old_value = '0;
        in_ch.new_value = '0;
        in_ch.lower_bound = '0;
        in_ch.upper_bound = '0;
        in_ch.is_bounded = 1'b0;
        in_ch.last_in = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_clamp_mode(1'b0);
        test_directed();
        test_full_buffer();
        test_clamp_mode();
        test_back_pressure();
        test_random();
        if (error_count == 0)
            $display("bounded_step_backtrack_unit_test: clean");
        else
            $display("bounded_step_backtrack_unit_test: errors");
        $finish;
    end
endmodule
